[hdl/ptach_pkg.sv]
`timescale 1ns / 1ps

package ptach_pkg;

    localparam int SPEED_BITS = 26;
    localparam int COUNT_BITS = 5;

    localparam logic [SPEED_BITS-1:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [SPEED_BITS-1:0] RPM_FLOOR     = 26'd50;

    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WRITE
    } ptach_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ptach_div_status_t;

endpackage

[hdl/pulse_tachometer_rpm_unit.sv]
`timescale 1ns / 1ps
// A result comes from a 26-step restoring divider, or is the numerator itself
// when the period is zero.
// The input is ready again only once a result moves to the output register, so
// no new item is taken while the divider runs; a second finished result holds
// the input until the first one is taken.
// Reset: asynchronous, active low; clears the level, edge time and period.
module pulse_tachometer_rpm_unit
    import ptach_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // Fields from bit 0: time_us[31:0], sensor_level[32], zero fill.
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // Fields from bit 0: speed_rpm[25:0], edge_seen[26], zero fill.
    output logic [OUT_DATA_BITS-1:0] m_tdata
);

    ptach_state_t          state_reg;
    ptach_state_t          state_next;
    logic                  level_reg;
    logic [TIME_BITS-1:0]  edge_time_reg;
    logic [TIME_BITS-1:0]  period_reg;
    logic [TIME_BITS-1:0]  period_next;
    logic                  rising_reg;
    logic [SPEED_BITS-1:0] speed_reg;
    logic [SPEED_BITS-1:0] speed_next;
    logic                  m_valid_reg;
    logic [SPEED_BITS-1:0] m_speed_reg;
    logic                  m_edge_reg;

    logic                  accept;
    logic                  load_out;
    logic [TIME_BITS-1:0]  now;
    logic                  sensor_level;
    logic                  rising;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  div_start;
    ptach_div_status_t     div_status;
    logic [SPEED_BITS-1:0] div_quotient;

    assign now          = TIME_BITS'(s_tdata[31:0]);
    assign sensor_level = s_tdata[32];
    assign rising       = sensor_level && !level_reg;
    assign elapsed      = now - edge_time_reg;

    always_comb
    begin
        if (rising || (elapsed > period_reg))
        begin
            period_next = elapsed;
        end
        else
        begin
            period_next = period_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        speed_next = speed_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (period_next == '0)
                    begin
                        speed_next = RPM_NUMERATOR;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    speed_next = (div_quotient < RPM_FLOOR) ? '0 : div_quotient;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= 1'b0;
            edge_time_reg <= '0;
            period_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                level_reg  <= sensor_level;
                period_reg <= period_next;
                if (rising)
                begin
                    edge_time_reg <= now;
                end
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        speed_reg <= speed_next;
        if (accept)
        begin
            rising_reg <= rising;
        end
        if (load_out)
        begin
            m_speed_reg <= speed_reg;
            m_edge_reg  <= rising_reg;
        end
    end

    ptach_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (period_next),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - SPEED_BITS - 1){1'b0}}, m_edge_reg, m_speed_reg};

endmodule

[hdl/ptach_div.sv]
`timescale 1ns / 1ps

module ptach_div
    import ptach_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [TIME_BITS-1:0]  divisor,
    output ptach_div_status_t     status,
    output logic [SPEED_BITS-1:0] quotient
);

    localparam int CMP_BITS = (TIME_BITS > SPEED_BITS) ? TIME_BITS + 1 : SPEED_BITS + 1;

    logic [TIME_BITS-1:0]  divisor_reg;
    logic [SPEED_BITS-1:0] rem_reg;
    logic [SPEED_BITS-1:0] rem_next;
    logic [SPEED_BITS-1:0] quo_reg;
    logic [SPEED_BITS-1:0] quo_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [CMP_BITS-1:0]   shifted;
    logic [CMP_BITS-1:0]   divisor_ext;
    logic [CMP_BITS-1:0]   diff;
    logic                  fits;

    // One restoring step per cycle, taking the numerator from its top bit down.
    always_comb
    begin
        shifted     = CMP_BITS'({rem_reg, RPM_NUMERATOR[cnt_reg]});
        divisor_ext = CMP_BITS'(divisor_reg);
        diff        = shifted - divisor_ext;
        fits        = (shifted >= divisor_ext);
        rem_next    = fits ? diff[SPEED_BITS-1:0] : shifted[SPEED_BITS-1:0];
        quo_next    = {quo_reg[SPEED_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= COUNT_BITS'(SPEED_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule
